// ----- sv/rse_pkg.sv -----
`timescale 1ns / 1ps

package rse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int OCC_W       = $clog2(STACK_DEPTH + 1);
  localparam int ID_W        = 32;
  localparam int CNT_W       = 31;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_EXTRACT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ID_W-1:0] id;
    logic [CNT_W-1:0]       cnt;
  } rec_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;     // accepted push, stack not full
    logic pop;      // accepted pop, stack not empty
    logic extract;  // accepted extract
  } cmd_t;

endpackage

// ----- sv/rse_cell.sv -----
`timescale 1ns / 1ps

module rse_cell
  import rse_pkg::*;
(
  input  logic                   clk_i,
  input  cmd_t                   cmd_i,
  input  logic signed [ID_W-1:0] key_i,
  input  logic                   valid_i,  // slot below occupancy
  input  rec_t                   above_i,  // neighbor closer to top
  input  rec_t                   below_i,  // neighbor farther from top
  input  logic                   found_i,  // match in a cell above
  output logic                   found_o,
  output rec_t                   entry_o,
  output rec_t                   pick_o    // entry if this is the first match
);

  rec_t entry_q, entry_d;
  logic hit;

  assign hit     = valid_i && (entry_q.id == key_i);
  assign found_o = found_i | hit;
  assign pick_o  = (hit && !found_i) ? entry_q : '0;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.push) begin
      entry_d = above_i;
    end else if (cmd_i.pop) begin
      entry_d = below_i;
    end else if (cmd_i.extract && found_o) begin
      // close the gap: matched cell and everything under it move up
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- sv/record_stack_with_extract_top.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Handshake              | Word
// --------+-----+------------------------+---------------------------------
// in      | in  | in_valid_i / in_stall_o | kind_i, key_id_i, book_count_i
// out     | out | out_valid_o / out_stall_i | status_o, rec_id_o, rec_count_o
//
// One word in, one word out; the result is registered and appears in the cycle after acceptance.
// Every operation finishes in the accept cycle: the cell row shifts in place,
// so one word per cycle is sustained while the output register drains.
// in_stall_o rises only while a result sits in the output register and out
// is stalled.
// Reset clears occupancy and the output valid; cell contents are left as is.

module record_stack_with_extract_top
  import rse_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              kind_i,
  input  logic signed [ID_W-1:0]  key_id_i,
  input  logic [CNT_W-1:0]        book_count_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [ID_W-1:0]  rec_id_o,
  output logic [CNT_W-1:0]        rec_count_o
);

  // cell 0 holds the top of stack
  logic [OCC_W-1:0]     occ_q, occ_d;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  rec_t                 rec_q, rec_d;

  logic                 accept;
  logic                 full, empty;
  op_e                  op;
  cmd_t                 cmd;
  rec_t                 push_rec;
  rec_t                 entry [STACK_DEPTH];
  rec_t                 pick  [STACK_DEPTH];
  logic [STACK_DEPTH:0] found_c;
  logic [STACK_DEPTH-1:0] cell_vld;
  rec_t                 pick_or;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign op         = op_e'(kind_i);
  assign full       = (occ_q == OCC_W'(STACK_DEPTH));
  assign empty      = (occ_q == '0);
  assign push_rec   = '{id: key_id_i, cnt: book_count_i};

  always_comb begin
    cmd         = '0;
    cmd.push    = accept && (op == OP_PUSH) && !full;
    cmd.pop     = accept && (op == OP_POP) && !empty;
    cmd.extract = accept && (op == OP_EXTRACT);
  end

  assign found_c[0] = 1'b0;

  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    rec_t above, below;

    assign cell_vld[k] = (OCC_W'(k) < occ_q);

    if (k == 0) begin : g_top
      assign above = push_rec;
    end else begin : g_mid
      assign above = entry[k-1];
    end

    if (k == STACK_DEPTH - 1) begin : g_bot
      assign below = entry[k];  // slot goes invalid; contents are don't care
    end else begin : g_nbot
      assign below = entry[k+1];
    end

    rse_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .key_i   (key_id_i),
      .valid_i (cell_vld[k]),
      .above_i (above),
      .below_i (below),
      .found_i (found_c[k]),
      .found_o (found_c[k+1]),
      .entry_o (entry[k]),
      .pick_o  (pick[k])
    );
  end

  // at most one pick is nonzero
  always_comb begin
    pick_or = '0;
    for (int k = 0; k < STACK_DEPTH; k++) begin
      pick_or = pick_or | pick[k];
    end
  end

  always_comb begin
    occ_d    = occ_q;
    status_d = status_q;
    rec_d    = rec_q;
    if (accept) begin
      status_d = ST_DONE;
      rec_d    = '0;
      unique case (op)
        OP_PUSH: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            occ_d = occ_q + OCC_W'(1);
          end
        end
        OP_POP: begin
          if (empty) begin
            status_d = ST_MISS;
            rec_d.id = '1;  // -1 flags an empty pop
          end else begin
            occ_d = occ_q - OCC_W'(1);
            rec_d = entry[0];
          end
        end
        OP_EXTRACT: begin
          if (found_c[STACK_DEPTH]) begin
            occ_d = occ_q - OCC_W'(1);
            rec_d = pick_or;
          end else begin
            status_d = ST_MISS;
          end
        end
        default: begin
          // unused kind: no state change, plain done
        end
      endcase
    end
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rec_q    <= rec_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign rec_id_o    = rec_q.id;
  assign rec_count_o = rec_q.cnt;

endmodule

// ----- sv/rse_checker.sv -----
`timescale 1ns / 1ps

module rse_checker
  import rse_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [1:0]             kind_i,
  input logic signed [ID_W-1:0] key_id_i,
  input logic [CNT_W-1:0]       book_count_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [1:0]             status_o,
  input logic signed [ID_W-1:0] rec_id_o,
  input logic [CNT_W-1:0]       rec_count_o
);

  // a held result word does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(rec_id_o) && $stable(rec_count_o))
    else $error("result word changed while stalled");

  // every accepted word yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // input is held off only by a stalled pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // a miss never returns a count; a full push returns nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_MISS || status_o == ST_FULL) |-> rec_count_o == '0)
    else $error("nonzero count on miss or full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> rec_id_o == '0)
    else $error("nonzero id on full push");

endmodule

bind record_stack_with_extract_top rse_checker u_rse_checker (.*);

// ----- tb/rse_reply_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels. It keeps its own copy of the record stack, predicts
// one reply word per accepted command word, and compares each accepted reply
// word with the oldest prediction.
module rse_reply_checker
  import rse_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [1:0]              kind_i,
  input  logic signed [ID_W-1:0]  key_id_i,
  input  logic [CNT_W-1:0]        book_count_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [1:0]              status_i,
  input  logic signed [ID_W-1:0]  rec_id_i,
  input  logic [CNT_W-1:0]        rec_count_i,
  output int                      pending_o,
  output int                      fails_o
);

  typedef struct packed {
    status_e                status;
    logic signed [ID_W-1:0] id;
    logic [CNT_W-1:0]       cnt;
  } reply_t;

  rec_t   shadow_stack [STACK_DEPTH];
  int     depth_used;
  int     mismatch_cnt;
  reply_t replies_due [$];
  reply_t oldest_due;

  // Applies one command word to the shadow stack, returns the reply word.
  function automatic reply_t apply_stack_op(logic [1:0] kind,
                                            logic signed [ID_W-1:0] key,
                                            logic [CNT_W-1:0] count_in);
    reply_t r;
    int     hit;
    r   = '{status: ST_DONE, id: '0, cnt: '0};
    hit = -1;
    case (kind)
      OP_PUSH: begin
        if (depth_used >= STACK_DEPTH) begin
          r.status = ST_FULL;  // record dropped
        end else begin
          shadow_stack[depth_used] = '{id: key, cnt: count_in};
          depth_used++;
        end
      end
      OP_POP: begin
        if (depth_used == 0) begin
          r.status = ST_MISS;
          r.id     = -1;
        end else begin
          depth_used--;
          r.id  = shadow_stack[depth_used].id;
          r.cnt = shadow_stack[depth_used].cnt;
        end
      end
      OP_EXTRACT: begin
        // nearest the top wins
        for (int i = depth_used - 1; i >= 0 && hit < 0; i--)
          if (shadow_stack[i].id == key) hit = i;
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.id  = shadow_stack[hit].id;
          r.cnt = shadow_stack[hit].cnt;
          for (int j = hit; j < depth_used - 1; j++)
            shadow_stack[j] = shadow_stack[j + 1];
          depth_used--;
        end
      end
      default: ;  // unused kind: no state change, all-zero reply
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_used   = 0;
      mismatch_cnt = 0;
      replies_due.delete();
      pending_o <= 0;
      fails_o   <= 0;
    end else begin
      // reply first: it can never belong to a word accepted at this edge
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          $error("reply word with no prediction pending");
          mismatch_cnt++;
        end else begin
          oldest_due = replies_due.pop_front();
          if (status_i !== oldest_due.status) begin
            $error("status: expected %0d, got %0d", oldest_due.status, status_i);
            mismatch_cnt++;
          end
          if (rec_id_i !== oldest_due.id) begin
            $error("rec_id: expected %0d, got %0d", oldest_due.id, rec_id_i);
            mismatch_cnt++;
          end
          if (rec_count_i !== oldest_due.cnt) begin
            $error("rec_count: expected %0d, got %0d", oldest_due.cnt, rec_count_i);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        replies_due.push_back(apply_stack_op(kind_i, key_id_i, book_count_i));
      pending_o <= replies_due.size();
      fails_o   <= mismatch_cnt;
    end
  end

endmodule

// ----- tb/record_stack_with_extract_top_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the record stack. The checker beside the block
// does all prediction and comparison; this module only drives words, applies
// back-pressure, and decides pass or fail at the end.
module record_stack_with_extract_top_tb;
  import rse_pkg::*;

  // kind code the block has no operation for: must reply all zero, no effect
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // quiet-cycle budget: far above the longest plausible stall streak
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int WORDS_PER_PHASE = 250;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [1:0]             kind_i;
  logic signed [ID_W-1:0] key_id_i;
  logic [CNT_W-1:0]       book_count_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [1:0]             status_o;
  logic signed [ID_W-1:0] rec_id_o;
  logic [CNT_W-1:0]       rec_count_o;

  int pending_words;
  int fail_total;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  record_stack_with_extract_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .key_id_i     (key_id_i),
    .book_count_i (book_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .rec_id_o     (rec_id_o),
    .rec_count_o  (rec_count_o)
  );

  rse_reply_checker reply_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .kind_i       (kind_i),
    .key_id_i     (key_id_i),
    .book_count_i (book_count_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .rec_id_i     (rec_id_o),
    .rec_count_i  (rec_count_o),
    .pending_o    (pending_words),
    .fails_o      (fail_total)
  );

  // Receiver: a fresh stall decision every cycle, held low through reset.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any accepted word on either side resets the quiet count.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL record_stack_with_extract_top");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a clock edge; returns at the edge where the word is taken.
  // Idle cycles drop valid; once raised, the word is held until accepted.
  task automatic send_word(logic [1:0] kind, logic signed [ID_W-1:0] id,
                           logic [CNT_W-1:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    key_id_i     <= id;
    book_count_i <= count;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Sender holds off until every predicted reply word has been taken.
  // pending_words is registered, so it lags the checker's queue and never reads early.
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  // Ids cluster on a few small values so extracts hit and duplicates occur;
  // the rest covers the extremes and every bit of the field.
  function automatic logic signed [ID_W-1:0] pick_id();
    case ($urandom_range(9))
      0:          return {1'b1, {(ID_W-1){1'b0}}};
      1:          return {1'b0, {(ID_W-1){1'b1}}};
      2, 3, 4, 5: return $urandom_range(4);
      6:          return -1;
      default:    return $urandom();
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CNT_W'($urandom());
    endcase
  endfunction

  // Random traffic in segments with a push bias: push-heavy segments run the
  // stack into full, pop-heavy ones into empty, balanced ones stay mid-depth.
  task automatic random_words(int count);
    int push_pct;
    int seg_left;
    int r;
    seg_left = 0;
    push_pct = 50;
    repeat (count) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 15);
        case ($urandom_range(2))
          0:       push_pct = 75;
          1:       push_pct = 20;
          default: push_pct = 45;
        endcase
      end
      seg_left--;
      r = $urandom_range(99);
      if (r == 99)
        send_word(OP_UNUSED, pick_id(), pick_count());
      else if (r < push_pct)
        send_word(OP_PUSH, pick_id(), pick_count());
      else if (r < push_pct + (99 - push_pct) / 2)
        send_word(OP_POP, pick_id(), pick_count());
      else
        send_word(OP_EXTRACT, pick_id(), pick_count());
    end
  endtask

  initial begin
    in_valid_i     <= 1'b0;
    kind_i         <= OP_PUSH;
    key_id_i       <= '0;
    book_count_i   <= '0;
    send_idle_pct  <= 21;
    recv_stall_pct <= 55;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-stack replies first, then extremes and extract rules.
    send_word(OP_POP,     32'sd9, '1);        // pop on empty: id -1
    send_word(OP_EXTRACT, 32'sd0, '0);        // extract on empty: miss
    send_word(OP_UNUSED,  32'sd7, 31'd5);     // unused kind, empty stack
    send_word(OP_PUSH,    {1'b1, {(ID_W-1){1'b0}}}, '0);
    send_word(OP_PUSH,    {1'b0, {(ID_W-1){1'b1}}}, '1);
    send_word(OP_PUSH,    -32'sd1, 31'h2aaa_aaaa);
    send_word(OP_PUSH,    32'sd3, 31'd100);
    send_word(OP_PUSH,    32'sd3, 31'd200);
    send_word(OP_EXTRACT, 32'sd3, '0);        // duplicate id: top one goes
    send_word(OP_EXTRACT, 32'sd7, '0);        // miss on a populated stack
    send_word(OP_EXTRACT, {1'b0, {(ID_W-1){1'b1}}}, '0);  // mid-stack removal
    send_word(OP_UNUSED,  32'sd3, 31'd1);     // unused kind must not disturb
    send_word(OP_POP,     32'sd0, '0);        // other id 3 record
    send_word(OP_POP,     32'sd0, '0);        // id -1: not the empty marker
    send_word(OP_PUSH,    32'sd0, 31'h5555_5555);
    send_word(OP_EXTRACT, 32'sd0, '0);        // hit on id 0, status tells it
    send_word(OP_POP,     32'sd0, '0);        // most negative id
    send_word(OP_POP,     32'sd0, '0);        // empty again
    drain_replies();

    // Three idling regimes; the sender drains fully at each boundary.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  <= 21;
          recv_stall_pct <= 55;
        end
        1: begin
          send_idle_pct  <= 55;
          recv_stall_pct <= 21;
        end
        default: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
      endcase
      random_words(WORDS_PER_PHASE);
      drain_replies();
    end

    // Short tail for any late stray word from the registered output stage.
    repeat (4) @(posedge clk_i);
    if (fail_total == 0 && pending_words == 0) begin
      $display("PASS record_stack_with_extract_top");
    end else begin
      $display("FAIL record_stack_with_extract_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/rse_pkg.sv
sv/rse_cell.sv
sv/record_stack_with_extract_top.sv
sv/rse_checker.sv
tb/rse_reply_checker.sv
tb/record_stack_with_extract_top_tb.sv
